// ===== design/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg - shared constants for the bounding sphere block
// Coordinate, store and result widths, and the packing of the stream words.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // point store geometry
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;

    // coordinate and result widths
    localparam int COORD_BITS = 16;
    localparam int PT_W       = 3 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int RAD_W      = COORD_BITS + 1;
    localparam int R2_W       = 2 * RAD_W;

    // square root unit: one result bit per step
    localparam int SQ_STEPS   = RAD_W;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS + 1);
    localparam int SQ_REM_W   = RAD_W + 3;

    // stream word widths
    localparam int IN_TDATA_W  = ((PT_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 6 * COORD_BITS + R2_W + RAD_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [2:0][COORD_BITS-1:0] point_t;

endpackage

// ===== design/bounding_sphere_from_points.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_from_points - box-midpoint bounding sphere of a point set
// Stores a set of 3D points, then reports center, furthest point and radius.
// ----------------------------------------------------------------------------
// Points load at one item per clock into a 1024-entry point store while the
// per-axis box is tracked. The item with tlast ends the set: input then stalls
// while the block computes the center, then walks the store through a
// read/square/sum pipeline at one stored point per clock and runs a
// bit-serial square root. The result then moves into the output register as
// soon as that register is free (an unread earlier result holds the block in
// the root step), and loading of the next set resumes on the next clock.
// Points beyond the store size are dropped and flagged in m_tuser. No
// clearing pass is needed after reset.
module bounding_sphere_from_points (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, point_z
    input  logic [bsp_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // center_x, center_y, center_z, far_x, far_y, far_z, radius_squared,
    // radius, zero fill
    output logic [bsp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // overflowed
    output logic [0:0]                      m_tuser
);

    localparam int CB = bsp_pkg::COORD_BITS;

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_CENTER = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_ROOT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [bsp_pkg::CNT_W-1:0] cnt_reg;
    logic                      ovf_reg;
    bsp_pkg::point_t           min_reg, max_reg, center_reg;
    bsp_pkg::point_t           pt_in;

    logic [bsp_pkg::PT_W-1:0]  mem [bsp_pkg::MAX_POINTS];
    logic [bsp_pkg::CNT_W-1:0] issue_reg;
    logic                      rd_en;
    logic [bsp_pkg::PT_W-1:0]  rd_data_reg;
    logic                      v1_reg, v2_reg, v3_reg;

    logic signed [bsp_pkg::DIFF_W-1:0] diff [3];
    logic signed [bsp_pkg::R2_W-1:0]   sq   [3];
    logic [bsp_pkg::R2_W-1:0]          sq_reg [3];
    logic [bsp_pkg::PT_W-1:0]          pt2_reg, pt3_reg, best_pt_reg;
    logic [bsp_pkg::R2_W-1:0]          dist_reg, best_d_reg;
    logic                              first_reg;

    logic                      in_fire, room, scan_done, out_free, finish;
    logic                      sqrt_done;
    logic [bsp_pkg::RAD_W-1:0] sqrt_root;

    bsp_pkg::point_t            o_center_reg;
    logic [bsp_pkg::PT_W-1:0]   o_far_reg;
    logic [bsp_pkg::R2_W-1:0]   o_r2_reg;
    logic [bsp_pkg::RAD_W-1:0]  o_rad_reg;
    logic                       o_ovf_reg;
    logic                       m_tvalid_reg;

    // handshake and store status
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_fire   = s_tvalid & s_tready;
    assign room      = (cnt_reg != bsp_pkg::CNT_W'(bsp_pkg::MAX_POINTS));
    assign rd_en     = (state_reg == ST_SCAN) && (issue_reg != cnt_reg);
    assign scan_done = (state_reg == ST_SCAN) && (issue_reg == cnt_reg)
                       && !v1_reg && !v2_reg && !v3_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign finish    = (state_reg == ST_ROOT) && sqrt_done && out_free;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pt_in[a] = s_tdata[a*CB +: CB];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (in_fire && s_tlast) state_next = ST_CENTER;
            ST_CENTER: state_next = ST_SCAN;
            ST_SCAN:   if (scan_done) state_next = ST_ROOT;
            ST_ROOT:   if (finish) state_next = ST_LOAD;
            default:   state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // point count and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (finish) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (in_fire) begin
            if (room) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // point store write and box tracking
    always_ff @(posedge aclk) begin
        if (in_fire && room) begin
            mem[cnt_reg[bsp_pkg::ADDR_W-1:0]] <= s_tdata[bsp_pkg::PT_W-1:0];
            for (int a = 0; a < 3; a++) begin
                if (cnt_reg == '0 || $signed(pt_in[a]) < $signed(min_reg[a])) begin
                    min_reg[a] <= pt_in[a];
                end
                if (cnt_reg == '0 || $signed(pt_in[a]) > $signed(max_reg[a])) begin
                    max_reg[a] <= pt_in[a];
                end
            end
        end
    end

    // box midpoint, floor of the halved sum
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CENTER) begin
            for (int a = 0; a < 3; a++) begin
                center_reg[a] <= CB'(($signed({min_reg[a][CB-1], min_reg[a]})
                                    + $signed({max_reg[a][CB-1], max_reg[a]})) >>> 1);
            end
        end
    end

    // store read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[issue_reg[bsp_pkg::ADDR_W-1:0]];
        end
    end

    // read address walk and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            if (state_reg == ST_CENTER) begin
                issue_reg <= '0;
            end else if (rd_en) begin
                issue_reg <= issue_reg + 1'b1;
            end
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // per-axis offset and square
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a] = $signed({rd_data_reg[a*CB+CB-1], rd_data_reg[a*CB +: CB]})
                      - $signed({center_reg[a][CB-1], center_reg[a]});
            sq[a]   = diff[a] * diff[a];
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            sq_reg[a] <= sq[a];
        end
        pt2_reg  <= rd_data_reg;
        dist_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        pt3_reg  <= pt2_reg;
    end

    // furthest point so far, ties keep the earlier one
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CENTER) begin
            first_reg <= 1'b1;
        end else if (v3_reg && (first_reg || dist_reg > best_d_reg)) begin
            first_reg   <= 1'b0;
            best_d_reg  <= dist_reg;
            best_pt_reg <= pt3_reg;
        end
    end

    bsp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_done),
        .radicand (best_d_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            o_center_reg <= center_reg;
            o_far_reg    <= best_pt_reg;
            o_r2_reg     <= best_d_reg;
            o_rad_reg    <= sqrt_root;
            o_ovf_reg    <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = bsp_pkg::OUT_TDATA_W'({o_rad_reg, o_r2_reg, o_far_reg, o_center_reg});
    assign m_tuser  = o_ovf_reg;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= bsp_pkg::CNT_W'(bsp_pkg::MAX_POINTS))
        else $error("point count beyond store size");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_reg <= cnt_reg))
        else $error("store walk ran past the stored points");

    a_set_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (state_reg == ST_LOAD && cnt_reg == '0 && !ovf_reg))
        else $error("set not cleared when result issued");

    a_root_start: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |=> (state_reg == ST_ROOT && !sqrt_done))
        else $error("square root start out of step");

endmodule

// ===== design/bsp_isqrt.sv =====
// ----------------------------------------------------------------------------
// bsp_isqrt - iterative integer square root
// Restoring digit-by-digit root, one result bit per clock; the result holds
// with done high until the next start.
// ----------------------------------------------------------------------------
module bsp_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bsp_pkg::R2_W-1:0]  radicand,
    output logic                      done,
    output logic [bsp_pkg::RAD_W-1:0] root
);

    logic [bsp_pkg::R2_W-1:0]     rad_reg;
    logic [bsp_pkg::SQ_REM_W-1:0] rem_reg;
    logic [bsp_pkg::RAD_W-1:0]    root_reg;
    logic [bsp_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [bsp_pkg::SQ_REM_W-1:0] rem_sh;
    logic [bsp_pkg::SQ_REM_W-1:0] trial;
    logic                         fits;

    // bring down the next two radicand bits and try a one
    assign rem_sh = {rem_reg[bsp_pkg::SQ_REM_W-3:0], rad_reg[bsp_pkg::R2_W-1 -: 2]};
    assign trial  = bsp_pkg::SQ_REM_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= bsp_pkg::SQ_CNT_W'(bsp_pkg::SQ_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == bsp_pkg::SQ_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[bsp_pkg::R2_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[bsp_pkg::RAD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== sim/bounding_sphere_from_points_tb.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_from_points_tb - testbench for the bounding sphere block
// Streams point sets into the block under random idling on both sides and
// checks every result against a cycle-free predictor or a directed table entry
// for center, furthest point, squared radius, radius and overflow flag.
// ----------------------------------------------------------------------------
module bounding_sphere_from_points_tb;

    localparam int COORD_BITS  = bsp_pkg::COORD_BITS;
    localparam int R2_W        = bsp_pkg::R2_W;
    localparam int RAD_W       = bsp_pkg::RAD_W;
    localparam int MAX_POINTS  = bsp_pkg::MAX_POINTS;
    localparam int IN_TDATA_W  = bsp_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = bsp_pkg::OUT_TDATA_W;

    typedef bsp_pkg::point_t point_t;

    // output word layout, lowest bit up
    localparam int CTR_LO     = 0;
    localparam int FAR_LO     = 3 * COORD_BITS;
    localparam int R2_LO      = 6 * COORD_BITS;
    localparam int RAD_LO     = R2_LO + R2_W;
    localparam int N_SETS     = 25;
    localparam int OVF_SET    = 14;
    localparam int N_DIR      = 32;
    localparam int EXP_DEPTH  = 16;
    localparam int WAIT_LIMIT = 20000;
    localparam int DRAIN_CYC  = 64;

    typedef struct packed {
        point_t          ctr;
        point_t          far_pt;
        logic [R2_W-1:0] r2;
        logic [RAD_W-1:0] rad;
        logic            ovf;
    } sphere_t;

    typedef struct packed {
        point_t  pt;
        bit      last;
        bit      typed;
        sphere_t want;
    } row_t;

    typedef enum int {MODE_FULL, MODE_SMALL, MODE_EXTREME, MODE_CLUSTER} coord_mode_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;

    // predictor state
    point_t  stored_pts [MAX_POINTS];
    int      n_stored   = 0;
    point_t  box_lo;
    point_t  box_hi;
    bit      dropped    = 1'b0;

    // expected results in order, written by the stimulus, read by the checker
    sphere_t exp_spheres [EXP_DEPTH];
    int      exp_wr        = 0;
    int      exp_rd        = 0;
    row_t    dir_rows [N_DIR];
    int      n_dir         = 0;
    int      n_mismatch    = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      idle_cycles   = 0;

    bounding_sphere_from_points uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic point_t pt3(int x, int y, int z);
        point_t p;
        p[0] = x[COORD_BITS-1:0];
        p[1] = y[COORD_BITS-1:0];
        p[2] = z[COORD_BITS-1:0];
        return p;
    endfunction

    function automatic sphere_t ball(point_t c, point_t f, longint r2, int rad);
        sphere_t s;
        s.ctr    = c;
        s.far_pt = f;
        s.r2     = r2[R2_W-1:0];
        s.rad    = rad[RAD_W-1:0];
        s.ovf    = 1'b0;
        return s;
    endfunction

    function automatic logic [RAD_W-1:0] floor_root(longint unsigned n);
        logic [RAD_W-1:0] r;
        longint unsigned  t;
        r = '0;
        for (int b = RAD_W - 1; b >= 0; b--) begin
            t = longint'(r) | (64'd1 << b);
            if (t * t <= n) r = t[RAD_W-1:0];
        end
        return r;
    endfunction

    function automatic longint unsigned dist_sq(point_t p, point_t c);
        longint          diff;
        longint unsigned s;
        s = 0;
        for (int a = 0; a < 3; a++) begin
            diff = longint'($signed(p[a])) - longint'($signed(c[a]));
            s += diff * diff;
        end
        return s;
    endfunction

    // append one row to the directed table
    task automatic add_row(input point_t pt, input bit last, input bit typed,
                           input sphere_t want);
        dir_rows[n_dir].pt    = pt;
        dir_rows[n_dir].last  = last;
        dir_rows[n_dir].typed = typed;
        dir_rows[n_dir].want  = want;
        n_dir++;
    endtask

    // store one point, and on the last one of a set compute the sphere
    task automatic predict_sphere(input point_t pt, input bit last,
                                  output bit got, output sphere_t res);
        logic signed [COORD_BITS:0] sum;
        longint unsigned            d;
        longint unsigned            best_d;
        int                         best;
        got = 1'b0;
        res = '0;
        if (n_stored < MAX_POINTS) begin
            for (int a = 0; a < 3; a++) begin
                if (n_stored == 0 || $signed(pt[a]) < $signed(box_lo[a])) box_lo[a] = pt[a];
                if (n_stored == 0 || $signed(pt[a]) > $signed(box_hi[a])) box_hi[a] = pt[a];
            end
            stored_pts[n_stored] = pt;
            n_stored++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            // box midpoint, floor of the halved sum
            for (int a = 0; a < 3; a++) begin
                sum = $signed({box_lo[a][COORD_BITS-1], box_lo[a]})
                    + $signed({box_hi[a][COORD_BITS-1], box_hi[a]});
                res.ctr[a] = sum[COORD_BITS:1];
            end
            // furthest point, earliest one wins a tie
            best   = 0;
            best_d = dist_sq(stored_pts[0], res.ctr);
            for (int i = 1; i < n_stored; i++) begin
                d = dist_sq(stored_pts[i], res.ctr);
                if (d > best_d) begin
                    best_d = d;
                    best   = i;
                end
            end
            res.far_pt = stored_pts[best];
            res.r2     = best_d[R2_W-1:0];
            res.rad    = floor_root(best_d);
            res.ovf    = dropped;
            got        = 1'b1;
            n_stored   = 0;
            dropped    = 1'b0;
        end
    endtask

    // hand one item to the block, then book its expected result
    task automatic feed(input point_t pt, input bit last, input bit typed,
                        input sphere_t want);
        bit      got;
        sphere_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_sphere(pt, last, got, res);
        if (got) begin
            exp_spheres[exp_wr % EXP_DEPTH] = typed ? want : res;
            exp_wr++;
        end
    endtask

    function automatic logic [COORD_BITS-1:0] gen_coord(coord_mode_t mode,
                                                        logic [COORD_BITS-1:0] base);
        logic [COORD_BITS-1:0] v;
        case (mode)
            MODE_SMALL: begin
                v = COORD_BITS'($urandom_range(8)) - COORD_BITS'(4);
            end
            MODE_EXTREME: begin
                case ($urandom_range(5))
                    0: v = 16'h8000;
                    1: v = 16'h8001;
                    2: v = 16'hffff;
                    3: v = 16'h0000;
                    4: v = 16'h7ffe;
                    default: v = 16'h7fff;
                endcase
            end
            MODE_CLUSTER: begin
                v = base + COORD_BITS'($urandom_range(255));
            end
            default: begin
                v = COORD_BITS'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // receiver side, stalls at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        sphere_t    w;
        string      axis;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_rd == exp_wr) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result with nothing expected: %0h / %0h", m_tdata, m_tuser);
            end else begin
                w = exp_spheres[exp_rd % EXP_DEPTH];
                exp_rd++;
                for (int a = 0; a < 3; a++) begin
                    axis = (a == 0) ? "x" : (a == 1) ? "y" : "z";
                    check_field({"center_", axis}, w.ctr[a],
                                m_tdata[CTR_LO + a*COORD_BITS +: COORD_BITS]);
                    check_field({"far_", axis}, w.far_pt[a],
                                m_tdata[FAR_LO + a*COORD_BITS +: COORD_BITS]);
                end
                check_field("radius_squared", w.r2, m_tdata[R2_LO +: R2_W]);
                check_field("radius", w.rad, m_tdata[RAD_LO +: RAD_W]);
                check_field("overflowed", w.ovf, m_tuser[0]);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WAIT_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        point_t      pt;
        coord_mode_t mode;
        logic [COORD_BITS-1:0] base;
        int          set_no;
        int          len;
        int          pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // single points: the point is its own center
        add_row(pt3(0, 0, 0), 1'b1, 1'b1,
                ball(pt3(0, 0, 0), pt3(0, 0, 0), 0, 0));
        add_row(pt3(32767, 32767, 32767), 1'b1, 1'b1,
                ball(pt3(32767, 32767, 32767), pt3(32767, 32767, 32767), 0, 0));
        add_row(pt3(-32768, -32768, -32768), 1'b1, 1'b1,
                ball(pt3(-32768, -32768, -32768), pt3(-32768, -32768, -32768),
                     0, 0));
        // full range box, center floors to -1
        add_row(pt3(-32768, -32768, -32768), 1'b0, 1'b0, '0);
        add_row(pt3(32767, 32767, 32767), 1'b1, 1'b1,
                ball(pt3(-1, -1, -1), pt3(32767, 32767, 32767),
                     64'd3221225472, 56755));
        // equal distances keep the first point
        add_row(pt3(10, 0, 0), 1'b0, 1'b0, '0);
        add_row(pt3(-10, 0, 0), 1'b1, 1'b1,
                ball(pt3(0, 0, 0), pt3(10, 0, 0), 100, 10));
        // negative odd sum rounds down
        add_row(pt3(-3, 5, 0), 1'b0, 1'b0, '0);
        add_row(pt3(0, 4, 0), 1'b1, 1'b1,
                ball(pt3(-2, 4, 0), pt3(0, 4, 0), 4, 2));
        // three points, two tied at the top
        add_row(pt3(3, 0, 0), 1'b0, 1'b0, '0);
        add_row(pt3(0, 3, 0), 1'b0, 1'b0, '0);
        add_row(pt3(0, 0, -3), 1'b1, 1'b1,
                ball(pt3(1, 1, -2), pt3(3, 0, 0), 9, 3));
        // radius squared not a perfect square
        add_row(pt3(0, 0, 0), 1'b0, 1'b0, '0);
        add_row(pt3(3, 4, 0), 1'b1, 1'b1,
                ball(pt3(1, 2, 0), pt3(3, 4, 0), 8, 2));
        // mixed set left to the predictor
        add_row(pt3(1234, -5678, 32767), 1'b0, 1'b0, '0);
        add_row(pt3(-32768, 100, -1), 1'b0, 1'b0, '0);
        add_row(pt3(0, -32768, 7), 1'b0, 1'b0, '0);
        add_row(pt3(-300, 2000, -32768), 1'b0, 1'b0, '0);
        add_row(pt3(32767, -1, 0), 1'b1, 1'b0, '0);

        for (int i = 0; i < n_dir; i++)
            feed(dir_rows[i].pt, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        // random sets, one of them filling the store and running past it
        for (set_no = 0; set_no < N_SETS; set_no++) begin
            case ((set_no / 6) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            if (set_no == OVF_SET) begin
                len = MAX_POINTS + 2;
            end else if ($urandom_range(9) == 0) begin
                len = $urandom_range(32, 9);
            end else begin
                len = $urandom_range(8, 1);
            end
            pick = $urandom_range(99);
            mode = (pick < 40) ? MODE_FULL : (pick < 65) ? MODE_SMALL :
                   (pick < 80) ? MODE_EXTREME : MODE_CLUSTER;
            base = COORD_BITS'($urandom);
            for (int i = 0; i < len; i++) begin
                pt[0] = gen_coord(mode, base);
                pt[1] = gen_coord(mode, base);
                pt[2] = gen_coord(mode, base);
                feed(pt, i == len - 1, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (exp_rd != exp_wr) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (n_mismatch == 0 && exp_rd == exp_wr) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bsp_pkg.sv
design/bsp_isqrt.sv
design/bounding_sphere_from_points.sv
sim/bounding_sphere_from_points_tb.sv
